FILE: rtl/core/fpr_pkg.sv
// Shared types and constants of the framed packet receiver.
`default_nettype none

package fpr_pkg;

  localparam int unsigned MaxPayloadDef = 32;
  localparam int unsigned BurstLimit    = 32;
  localparam int unsigned BurstCntW     = 6;
  localparam int unsigned CountW        = 9;
  localparam logic [CountW-1:0] CountMax = 9'd511;

  localparam logic [7:0] HeadReset  = 8'hAA;
  localparam logic [7:0] TailReset  = 8'h55;
  localparam logic       CheckReset = 1'b1;

  typedef enum logic [1:0] {
    CfgHead  = 2'd0,
    CfgTail  = 2'd1,
    CfgCheck = 2'd2,
    CfgNone  = 2'd3
  } fpr_cfg_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkFetch,
    BkEmit
  } fpr_bk_e;

  typedef struct packed {
    logic [7:0]           id;
    logic [7:0]           len;
    logic [BurstCntW-1:0] cnt;
  } fpr_desc_t;

endpackage

`default_nettype wire

FILE: rtl/core/framed_packet_receiver_top.sv
// Top level of the framed packet receiver.
`default_nettype none

// Parses head, id, length, payload, checksum, tail frames from a byte stream and delivers
// each accepted frame as a burst of one result per stored payload byte, at most BurstLimit
// (an empty frame gives one marker result with has_payload low). The front end takes one
// byte per cycle while full is low; it holds full high while a delivered frame is still
// being read out and the next byte would be written to the payload store, or while two
// delivered frames wait in the descriptor queue. The back end fetches each result by a
// registered read of the payload RAM and then loads it into the result register once that
// is free, before it fetches the next; a marker result skips the read.
module framed_packet_receiver_top #(
  parameter int unsigned MaxPayload = fpr_pkg::MaxPayloadDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic      [7:0] msg_id_o,
  output logic      [7:0] frame_len_o,
  output logic      [4:0] byte_pos_o,
  output logic      [7:0] payload_byte_o,
  output logic            has_payload_o,
  output logic            last_o
);

  import fpr_pkg::*;

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             desc_push, desc_pop, q_full, q_empty, busy, pending;
  fpr_desc_t        desc_in, desc_out;

  assign cfg_ready_o = 1'b1;
  assign pending     = !q_empty || busy;

  fpr_front #(
    .MaxPayload (MaxPayload),
    .AddrW      (AddrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .pending_i   (pending),
    .q_full_i    (q_full),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .desc_push_o (desc_push),
    .desc_o      (desc_in)
  );

  fpr_ram #(
    .Width (8),
    .Depth (MaxPayload),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpr_dq u_dq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .wdata_i (desc_in),
    .pop_i   (desc_pop),
    .rdata_o (desc_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fpr_back #(
    .MaxPayload (MaxPayload),
    .AddrW      (AddrW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_valid_i   (!q_empty),
    .desc_i         (desc_out),
    .desc_pop_o     (desc_pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .busy_o         (busy),
    .pop_i          (pop),
    .empty_o        (empty),
    .msg_id_o       (msg_id_o),
    .frame_len_o    (frame_len_o),
    .byte_pos_o     (byte_pos_o),
    .payload_byte_o (payload_byte_o),
    .has_payload_o  (has_payload_o),
    .last_o         (last_o)
  );

  a_no_write_during_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !pending)
    else $error("payload store written while a burst is pending");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_push |-> !q_full)
    else $error("frame descriptor lost on full queue");

  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_payload_o) |-> (last_o && payload_byte_o == 8'd0 && byte_pos_o == 5'd0))
    else $error("malformed empty-frame marker");

  a_read_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (busy && !ram_we))
    else $error("payload read outside a burst");

endmodule

`default_nettype wire

FILE: rtl/core/fpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/fpr_front.sv
// Front end: configuration registers, frame parser, payload store writes, frame hand-off.
`default_nettype none

module fpr_front #(
  parameter int unsigned MaxPayload = fpr_pkg::MaxPayloadDef,
  parameter int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             push_i,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  full_o,
  input  wire logic             pending_i,
  input  wire logic             q_full_i,
  output logic                  ram_we_o,
  output logic      [AddrW-1:0] ram_waddr_o,
  output logic      [7:0]       ram_wdata_o,
  output logic                  desc_push_o,
  output fpr_pkg::fpr_desc_t    desc_o
);

  import fpr_pkg::*;

  localparam int unsigned BurstCap = (MaxPayload < BurstLimit) ? MaxPayload : BurstLimit;

  logic [7:0]        head_q, head_d, tail_q, tail_d;
  logic              chk_q, chk_d;
  logic              in_frame_q, in_frame_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [7:0]        sum_q, sum_d, id_q, id_d, len_q, len_d, rsum_q, rsum_d;
  logic [CountW-1:0] lenp2, pos;
  logic              pay_next, acc;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    chk_d  = chk_q;
    if (cfg_valid_i) begin
      case (fpr_cfg_e'(cfg_index_i))
        CfgHead:  head_d = cfg_data_i;
        CfgTail:  tail_d = cfg_data_i;
        CfgCheck: chk_d  = cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  assign lenp2    = CountW'(len_q) + CountW'(2);
  assign pos      = cnt_q - CountW'(2);
  assign pay_next = in_frame_q && (cnt_q >= CountW'(2)) && (cnt_q < lenp2)
                    && (pos < CountW'(MaxPayload));
  assign full_o   = q_full_i || (pending_i && pay_next);
  assign acc      = push_i && !full_o;

  always_comb begin
    in_frame_d  = in_frame_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    id_d        = id_q;
    len_d       = len_q;
    rsum_d      = rsum_q;
    ram_we_o    = 1'b0;
    desc_push_o = 1'b0;
    if (acc) begin
      if (!in_frame_q) begin
        if (rx_byte_i == head_q) begin
          in_frame_d = 1'b1;
          cnt_d      = '0;
          sum_d      = '0;
        end
      end else if (rx_byte_i == tail_q) begin
        in_frame_d  = 1'b0;
        desc_push_o = !chk_q || (sum_q == rsum_q);
      end else begin
        if (cnt_q == CountW'(0)) begin
          id_d = rx_byte_i;
        end else if (cnt_q == CountW'(1)) begin
          len_d = rx_byte_i;
        end else if (cnt_q < lenp2) begin
          ram_we_o = pos < CountW'(MaxPayload);
          sum_d    = sum_q + rx_byte_i;
        end else if (cnt_q == lenp2) begin
          rsum_d = rx_byte_i;
        end else if (cnt_q > lenp2 + CountW'(1)) begin
          in_frame_d = 1'b0;
        end
        if (cnt_q != CountMax) begin
          cnt_d = cnt_q + CountW'(1);
        end
      end
    end
  end

  assign ram_waddr_o = AddrW'(pos);
  assign ram_wdata_o = rx_byte_i;

  assign desc_o.id  = id_q;
  assign desc_o.len = len_q;
  assign desc_o.cnt = (len_q > 8'(BurstCap)) ? BurstCntW'(BurstCap) : BurstCntW'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= HeadReset;
      tail_q     <= TailReset;
      chk_q      <= CheckReset;
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      sum_q      <= '0;
      id_q       <= '0;
      len_q      <= '0;
      rsum_q     <= '0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      chk_q      <= chk_d;
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      id_q       <= id_d;
      len_q      <= len_d;
      rsum_q     <= rsum_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fpr_dq.sv
// Two-entry queue of delivered frame descriptors between front and back end.
`default_nettype none

module fpr_dq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire fpr_pkg::fpr_desc_t wdata_i,
  input  wire logic          pop_i,
  output fpr_pkg::fpr_desc_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  import fpr_pkg::*;

  fpr_desc_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fpr_back.sv
// Back end: reads stored payload for each delivered frame and drives the result register.
`default_nettype none

module fpr_back #(
  parameter int unsigned MaxPayload = fpr_pkg::MaxPayloadDef,
  parameter int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             desc_valid_i,
  input  wire fpr_pkg::fpr_desc_t desc_i,
  output logic                  desc_pop_o,
  output logic                  ram_re_o,
  output logic      [AddrW-1:0] ram_raddr_o,
  input  wire logic [7:0]       ram_rdata_i,
  output logic                  busy_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [7:0]       msg_id_o,
  output logic      [7:0]       frame_len_o,
  output logic      [4:0]       byte_pos_o,
  output logic      [7:0]       payload_byte_o,
  output logic                  has_payload_o,
  output logic                  last_o
);

  import fpr_pkg::*;

  fpr_bk_e   state_q, state_d;
  fpr_desc_t desc_q, desc_d;
  logic [4:0] k_q, k_d;
  logic       ov_q, ov_d;
  logic [7:0] id_q, id_d, len_q, len_d, pb_q, pb_d;
  logic [4:0] pos_q, pos_d;
  logic       hp_q, hp_d, last_q, last_d;
  logic       free, load, marker, is_last;

  assign free    = !ov_q || pop_i;
  assign marker  = desc_q.cnt == '0;
  assign is_last = (BurstCntW'(k_q) + BurstCntW'(1)) == desc_q.cnt;

  always_comb begin
    state_d    = state_q;
    desc_d     = desc_q;
    k_d        = k_q;
    desc_pop_o = 1'b0;
    ram_re_o   = 1'b0;
    load       = 1'b0;
    case (state_q)
      BkIdle: begin
        if (desc_valid_i) begin
          desc_pop_o = 1'b1;
          desc_d     = desc_i;
          k_d        = '0;
          state_d    = (desc_i.cnt == '0) ? BkEmit : BkFetch;
        end
      end
      BkFetch: begin
        ram_re_o = 1'b1;
        state_d  = BkEmit;
      end
      BkEmit: begin
        if (free) begin
          load = 1'b1;
          if (marker || is_last) begin
            state_d = BkIdle;
          end else begin
            k_d     = k_q + 5'd1;
            state_d = BkFetch;
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    ov_d   = ov_q && !pop_i;
    id_d   = id_q;
    len_d  = len_q;
    pos_d  = pos_q;
    pb_d   = pb_q;
    hp_d   = hp_q;
    last_d = last_q;
    if (load) begin
      ov_d   = 1'b1;
      id_d   = desc_q.id;
      len_d  = desc_q.len;
      pos_d  = marker ? 5'd0 : k_q;
      pb_d   = marker ? 8'd0 : ram_rdata_i;
      hp_d   = !marker;
      last_d = marker || is_last;
    end
  end

  assign ram_raddr_o    = AddrW'(k_q);
  assign busy_o         = state_q != BkIdle;
  assign empty_o        = !ov_q;
  assign msg_id_o       = id_q;
  assign frame_len_o    = len_q;
  assign byte_pos_o     = pos_q;
  assign payload_byte_o = pb_q;
  assign has_payload_o  = hp_q;
  assign last_o         = last_q;

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    k_q    <= k_d;
    id_q   <= id_d;
    len_q  <= len_d;
    pos_q  <= pos_d;
    pb_q   <= pb_d;
    hp_q   <= hp_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

`default_nettype wire

FILE: sim/framed_packet_receiver_top_tb.sv
`timescale 1ns / 100ps

// Self-checking testbench for the framed packet receiver: random framed byte traffic
// with a scoreboard.

typedef struct packed {
  logic [7:0] id;
  logic [7:0] len;
  logic [4:0] pos;
  logic [7:0] data;
  logic       has_data;
  logic       last;
} frame_beat_t;

class frame_scoreboard;
  logic [7:0]  head_byte;
  logic [7:0]  tail_byte;
  logic        check_en;
  bit          in_frame;
  int unsigned byte_cnt;
  logic [7:0]  sum_acc;
  logic [7:0]  frame_id;
  logic [7:0]  frame_len;
  logic [7:0]  frame_chk;
  logic [7:0]  store [fpr_pkg::MaxPayloadDef];
  bit          written [fpr_pkg::MaxPayloadDef];
  frame_beat_t beats_due [$];
  int          errors;

  function new();
    head_byte = fpr_pkg::HeadReset;
    tail_byte = fpr_pkg::TailReset;
    check_en  = fpr_pkg::CheckReset;
    in_frame  = 1'b0;
    byte_cnt  = 0;
    sum_acc   = 8'd0;
    frame_id  = 8'd0;
    frame_len = 8'd0;
    frame_chk = 8'd0;
    errors    = 0;
  endfunction

  function void set_reg(fpr_pkg::fpr_cfg_e idx, logic [7:0] value);
    case (idx)
      fpr_pkg::CfgHead:  head_byte = value;
      fpr_pkg::CfgTail:  tail_byte = value;
      fpr_pkg::CfgCheck: check_en  = value[0];
      default: ;
    endcase
  endfunction

  function int burst_len();
    int n;
    n = frame_len;
    if (n > fpr_pkg::MaxPayloadDef) n = fpr_pkg::MaxPayloadDef;
    if (n > fpr_pkg::BurstLimit) n = fpr_pkg::BurstLimit;
    return n;
  endfunction

  function bit delivers(logic [7:0] b);
    return in_frame && b == tail_byte && (!check_en || sum_acc == frame_chk);
  endfunction

  function bit reads_unwritten(logic [7:0] b);
    if (!delivers(b)) return 1'b0;
    for (int k = 0; k < burst_len(); k++) begin
      if (!written[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Returns 1 unless the byte is ignored while waiting for a head.
  function bit note_byte(logic [7:0] b);
    int n;
    if (!in_frame) begin
      if (b == head_byte) begin
        in_frame = 1'b1;
        byte_cnt = 0;
        sum_acc  = 8'd0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (b == tail_byte) begin
      if (delivers(b)) begin
        n = burst_len();
        if (frame_len == 8'd0) begin
          beats_due.push_back(frame_beat_t'{frame_id, 8'd0, 5'd0, 8'd0, 1'b0, 1'b1});
        end else begin
          for (int k = 0; k < n; k++) begin
            beats_due.push_back(frame_beat_t'{frame_id, frame_len, 5'(k), store[k], 1'b1,
                                              1'((k + 1) == n)});
          end
        end
      end
      in_frame = 1'b0;
      return 1'b1;
    end
    if (byte_cnt == 0) begin
      frame_id = b;
    end else if (byte_cnt == 1) begin
      frame_len = b;
    end else if (byte_cnt < 2 + frame_len) begin
      if (byte_cnt - 2 < fpr_pkg::MaxPayloadDef) begin
        store[byte_cnt - 2]   = b;
        written[byte_cnt - 2] = 1'b1;
      end
      sum_acc = sum_acc + b;
    end else if (byte_cnt == 2 + frame_len) begin
      frame_chk = b;
    end else if (byte_cnt > 3 + frame_len) begin
      in_frame = 1'b0;
    end
    if (byte_cnt < fpr_pkg::CountMax) byte_cnt++;
    return 1'b1;
  endfunction

  function int pending();
    return beats_due.size();
  endfunction

  task report(string msg);
    if (errors < 50) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task compare(string field, int want, int got);
    if (want !== got) report($sformatf("%s: expected %0h, got %0h", field, want, got));
  endtask

  task check_result(frame_beat_t got);
    frame_beat_t want;
    if (beats_due.size() == 0) begin
      report($sformatf("unexpected result id %0h pos %0d", got.id, got.pos));
      return;
    end
    want = beats_due.pop_front();
    compare("msg_id", want.id, got.id);
    compare("frame_len", want.len, got.len);
    compare("byte_pos", want.pos, got.pos);
    compare("payload_byte", want.data, got.data);
    compare("has_payload", want.has_data, got.has_data);
    compare("last", want.last, got.last);
  endtask
endclass

module framed_packet_receiver_top_tb;
  import fpr_pkg::*;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_valid_i    = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i    = 2'd0;
  logic [7:0] cfg_data_i     = 8'd0;
  logic       push           = 1'b0;
  logic       full;
  logic [7:0] rx_byte_i      = 8'd0;
  logic       empty;
  logic       pop            = 1'b0;
  logic [7:0] msg_id_o;
  logic [7:0] frame_len_o;
  logic [4:0] byte_pos_o;
  logic [7:0] payload_byte_o;
  logic       has_payload_o;
  logic       last_o;

  frame_scoreboard sb = new();
  int hold_cycles = 0;
  int counted     = 0;
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;

  framed_packet_receiver_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(33, 40);
    if (r == 2) return $urandom_range(9, 32);
    return $urandom_range(1, 8);
  endfunction

  task automatic drop_push();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? gap_len() : 0;
    // steer clear of a burst that would read payload slots never filled
    if (sb.reads_unwritten(b)) b = b ^ 8'h01;
    if (gap > 0) begin
      drop_push();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    if (sb.note_byte(b)) counted++;
  endtask

  task automatic settle();
    int n;
    n = 0;
    drop_push();
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input fpr_cfg_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // flaw: 0 clean, 1 bad checksum, 2 one spare byte, 3 overrun, 4 cut short
  task automatic send_frame(input int len, input int flaw);
    logic [7:0] body [$];
    logic [7:0] sum;
    logic [7:0] b;
    int cut;
    sum = 8'd0;
    body.push_back(8'($urandom));
    body.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      body.push_back(b);
      sum = sum + b;
    end
    body.push_back(flaw == 1 ? sum ^ 8'($urandom_range(1, 255)) : sum);
    if (flaw >= 2 && flaw <= 3) body.push_back(8'($urandom));
    if (flaw == 3) body.push_back(8'($urandom));
    if (flaw == 4) begin
      cut = $urandom_range(0, 8);
      if (cut > body.size() - 1) cut = body.size() - 1;
      body = body[0:cut];
    end
    push_byte(sb.head_byte);
    foreach (body[i]) push_byte(body[i]);
    push_byte(sb.tail_byte);
  endtask

  task automatic random_traffic(input int target);
    int stop;
    int r;
    stop = counted + target;
    while (counted < stop) begin
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        send_frame(pick_len(), 0);
      end else if (r == 6) begin
        send_frame(pick_len(), 2);
      end else if (r == 7) begin
        send_frame(pick_len(), $urandom_range(0, 1) ? 1 : 3);
      end else if (r == 8) begin
        send_frame($urandom_range(0, 255), 4);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_result(frame_beat_t'{msg_id_o, frame_len_o, byte_pos_o, payload_byte_o,
                                      has_payload_o, last_o});
      end
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (rx_idle && $urandom_range(0, 2) == 0) stall = gap_len();
      end
    end
  end

  initial begin : stimulus
    logic [7:0] opening [] = '{
      8'hAA, 8'h01, 8'h02, 8'h00, 8'hFF, 8'hFF, 8'h55,
      8'hAA, 8'h07, 8'h00, 8'h00, 8'h55,
      8'hAA, 8'hAA, 8'h55,
      8'hAA, 8'h02, 8'h01, 8'h10, 8'h11, 8'h55,
      8'hAA, 8'h03, 8'h00, 8'h00, 8'h12, 8'h34, 8'h55
    };
    logic [7:0] v;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) push_byte(opening[i]);
    settle();

    write_reg(CfgHead, 8'h00);
    write_reg(CfgTail, 8'hFF);
    random_traffic(40);
    settle();

    write_reg(CfgHead, 8'hFF);
    write_reg(CfgTail, 8'h00);
    write_reg(CfgCheck, 8'($urandom) & 8'hFE);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_traffic(30);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    settle();

    write_reg(CfgNone, 8'($urandom));
    write_reg(CfgHead, 8'($urandom));
    write_reg(CfgTail, 8'($urandom));
    write_reg(CfgCheck, 8'($urandom) | 8'h01);
    random_traffic(40);
    settle();

    v = 8'($urandom);
    write_reg(CfgHead, v);
    write_reg(CfgTail, v);
    random_traffic(30);
    settle();

    write_reg(CfgHead, 8'hAA);
    write_reg(CfgTail, 8'h55);
    write_reg(CfgCheck, 8'($urandom) & 8'hFE);
    random_traffic(30);
    settle();

    // hold the result side off while full frames keep arriving
    write_reg(CfgCheck, 8'h01);
    tx_idle     = 1'b0;
    hold_cycles = 500;
    repeat (6) send_frame(32, 0);
    tx_idle = 1'b1;
    random_traffic(40);
    settle();

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: framed_packet_receiver_top.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_ram.sv
rtl/core/fpr_front.sv
rtl/core/fpr_dq.sv
rtl/core/fpr_back.sv
rtl/core/framed_packet_receiver_top.sv
sim/framed_packet_receiver_top_tb.sv
